[rtl/core/spicds_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spicds_pkg
// Shared types and constants for the serial clock prescaler and rate search.
// ----------------------------------------------------------------------------
package spicds_pkg;

   localparam int unsigned CLK_W  = 32;
   localparam int unsigned ACC_W  = 48;
   localparam int unsigned BYTE_W = 8;

   localparam logic [CLK_W-1:0] SYSTEM_CLOCK_RESET    = 32'd120000000;
   localparam logic [CLK_W-1:0] ALTERNATE_CLOCK_RESET = 32'd16000000;

   localparam logic [BYTE_W-1:0] PRESCALER_FIRST = 8'd2;
   localparam logic [BYTE_W-1:0] PRESCALER_STEP  = 8'd2;
   localparam logic [BYTE_W-1:0] PRESCALER_LAST  = 8'd254;
   localparam logic [BYTE_W-1:0] RATE_LAST       = 8'd255;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [1:0] {
      CSR_SYSTEM_CLOCK = 2'd0,
      CSR_ALTERNATE_CLOCK = 2'd1,
      CSR_USE_ALTERNATE = 2'd2,
      CSR_MASTER_MODE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CLK_W-1:0] source_hz;
      logic [CLK_W-1:0] target_hz;
      logic             master_mode;
   } job_type;

   typedef struct packed {
      logic              status;
      logic [BYTE_W-1:0] prescaler;
      logic [BYTE_W-1:0] clock_rate;
   } result_type;

endpackage
`default_nettype wire

[rtl/core/spicds_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spicds_search
// Sequencer around one shared 48-bit adder and comparator: limit check, then
// a walk over (prescaler, divisor) pairs, one pair per cycle.
// ----------------------------------------------------------------------------
module spicds_search (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire spicds_pkg::job_type    job,
   output logic                        ready,
   output logic                        done,
   input  wire logic                   take,
   output spicds_pkg::result_type      result
);

   spicds_pkg::state_type state_ff, state_in;

   logic [spicds_pkg::CLK_W-1:0]  src_ff, src_in;
   logic [spicds_pkg::CLK_W-1:0]  tgt_ff, tgt_in;
   logic [spicds_pkg::CLK_W:0]    tp1_ff, tp1_in;
   logic                          master_ff, master_in;
   logic [spicds_pkg::ACC_W-1:0]  step_ff, step_in;
   logic [spicds_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [spicds_pkg::BYTE_W-1:0] presc_ff, presc_in;
   logic [spicds_pkg::BYTE_W-1:0] rate_ff, rate_in;
   logic                          status_ff, status_in;

   logic [spicds_pkg::ACC_W-1:0]  add_a, add_b, sum, cmp_rhs;
   logic                          below, wrap, last_p;

   assign wrap   = (rate_ff == spicds_pkg::RATE_LAST);
   assign last_p = (presc_ff == spicds_pkg::PRESCALER_LAST);

   // shared adder
   always_comb begin
      add_a = '0;
      add_b = '0;
      unique case (state_ff)
         spicds_pkg::ST_CHECK: begin
            if (master_ff) begin
               add_a = {15'd0, tgt_ff, 1'b0};
            end else begin
               add_a = {13'd0, tgt_ff, 3'd0};
               add_b = {14'd0, tgt_ff, 2'd0};
            end
         end
         spicds_pkg::ST_SEARCH: begin
            if (wrap) begin
               add_a = step_ff;
               add_b = {14'd0, tp1_ff, 1'b0};
            end else begin
               add_a = acc_ff;
               add_b = step_ff;
            end
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   assign sum     = add_a + add_b;
   assign cmp_rhs = (state_ff == spicds_pkg::ST_CHECK) ? sum : acc_ff;
   assign below   = ({16'd0, src_ff} < cmp_rhs);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spicds_pkg::ST_IDLE: begin
            if (start) state_in = spicds_pkg::ST_CHECK;
         end
         spicds_pkg::ST_CHECK: begin
            state_in = below ? spicds_pkg::ST_DONE : spicds_pkg::ST_SEARCH;
         end
         spicds_pkg::ST_SEARCH: begin
            if (below || (wrap && last_p)) state_in = spicds_pkg::ST_DONE;
         end
         spicds_pkg::ST_DONE: begin
            if (take) state_in = spicds_pkg::ST_IDLE;
         end
         default: state_in = spicds_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      src_in    = src_ff;
      tgt_in    = tgt_ff;
      tp1_in    = tp1_ff;
      master_in = master_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      presc_in  = presc_ff;
      rate_in   = rate_ff;
      status_in = status_ff;
      unique case (state_ff)
         spicds_pkg::ST_IDLE: begin
            if (start) begin
               src_in    = job.source_hz;
               tgt_in    = job.target_hz;
               tp1_in    = {1'b0, job.target_hz} + 33'd1;
               master_in = job.master_mode;
            end
         end
         spicds_pkg::ST_CHECK: begin
            step_in   = {14'd0, tp1_ff, 1'b0};
            acc_in    = {14'd0, tp1_ff, 1'b0};
            presc_in  = spicds_pkg::PRESCALER_FIRST;
            rate_in   = '0;
            status_in = spicds_pkg::STATUS_OK;
            if (below) begin
               status_in = spicds_pkg::STATUS_ERROR;
               presc_in  = '0;
            end
         end
         spicds_pkg::ST_SEARCH: begin
            if (below) begin
               status_in = spicds_pkg::STATUS_OK;
            end else if (wrap) begin
               rate_in = '0;
               if (last_p) begin
                  status_in = spicds_pkg::STATUS_ERROR;
                  presc_in  = '0;
               end else begin
                  presc_in = presc_ff + spicds_pkg::PRESCALER_STEP;
                  step_in  = sum;
                  acc_in   = sum;
               end
            end else begin
               rate_in = rate_ff + 8'd1;
               acc_in  = sum;
            end
         end
         spicds_pkg::ST_DONE: begin
            status_in = status_ff;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      ready             = (state_ff == spicds_pkg::ST_IDLE);
      done              = (state_ff == spicds_pkg::ST_DONE);
      result.status     = status_ff;
      result.prescaler  = presc_ff;
      result.clock_rate = rate_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spicds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      tgt_ff    <= tgt_in;
      tp1_ff    <= tp1_in;
      master_ff <= master_in;
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      presc_ff  <= presc_in;
      rate_ff   <= rate_in;
      status_ff <= status_in;
   end

   // checks
   a_start_checks: assert property (@(posedge clock) disable iff (reset)
      (ready && start) |=> (state_ff == spicds_pkg::ST_CHECK))
      else $error("search did not begin with the limit check");

   a_ok_even: assert property (@(posedge clock) disable iff (reset)
      (done && (status_ff == spicds_pkg::STATUS_OK)) |->
         (presc_ff[0] == 1'b0 && presc_ff != 8'd0))
      else $error("good result with odd or zero prescaler");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (done && (status_ff == spicds_pkg::STATUS_ERROR)) |->
         (presc_ff == 8'd0 && rate_ff == 8'd0))
      else $error("error result with nonzero fields");

   a_acc_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spicds_pkg::ST_SEARCH) |-> (acc_ff >= step_ff))
      else $error("product accumulator below its step");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (done && !take) |=> (done && $stable(presc_ff) && $stable(rate_ff)))
      else $error("result changed before it was taken");

endmodule
`default_nettype wire

[rtl/core/spi_clock_divider_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spi_clock_divider_search
// Serial clock prescaler and rate search over even prescalers and all rate divisors.
// ----------------------------------------------------------------------------
// a req beat starts the limit check, then the search tries n pairs, n = pairs tried (0 when refused)
// n is at most 127 * 256 = 32512, one (prescaler, divisor) pair per cycle
// through the shared 48-bit adder and comparator in the search unit
// one item at a time, no new req beat is taken before the last result; req_tready returns when the result
// moves to the rsp register
// reset (synchronous, active high) clears the sequencer and output valid and
// restores the clock, source select and mode registers to their defaults
module spi_clock_divider_search (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] target_hz
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [0] status, [8:1] prescaler, [16:9] clock_rate
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic [spicds_pkg::CLK_W-1:0] sys_clk_ff, sys_clk_in;
   logic [spicds_pkg::CLK_W-1:0] alt_clk_ff, alt_clk_in;
   logic                         use_alt_ff, use_alt_in;
   logic                         master_ff, master_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [23:0]                  rsp_data_ff, rsp_data_in;

   spicds_pkg::job_type          job;
   spicds_pkg::result_type       result;
   logic                         eng_ready, eng_done, take;

   // config registers
   always_comb begin
      sys_clk_in = sys_clk_ff;
      alt_clk_in = alt_clk_ff;
      use_alt_in = use_alt_ff;
      master_in  = master_ff;
      if (csr_wen) begin
         unique case (spicds_pkg::csr_index_type'(csr_index))
            spicds_pkg::CSR_SYSTEM_CLOCK:    sys_clk_in = csr_wdata;
            spicds_pkg::CSR_ALTERNATE_CLOCK: alt_clk_in = csr_wdata;
            spicds_pkg::CSR_USE_ALTERNATE:   use_alt_in = csr_wdata[0];
            spicds_pkg::CSR_MASTER_MODE:     master_in  = csr_wdata[0];
            default:                         sys_clk_in = sys_clk_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_clk_ff <= spicds_pkg::SYSTEM_CLOCK_RESET;
         alt_clk_ff <= spicds_pkg::ALTERNATE_CLOCK_RESET;
         use_alt_ff <= 1'b0;
         master_ff  <= 1'b1;
      end else begin
         sys_clk_ff <= sys_clk_in;
         alt_clk_ff <= alt_clk_in;
         use_alt_ff <= use_alt_in;
         master_ff  <= master_in;
      end
   end

   assign job.source_hz   = use_alt_ff ? alt_clk_ff : sys_clk_ff;
   assign job.target_hz   = req_tdata;
   assign job.master_mode = master_ff;

   assign req_tready = eng_ready;
   assign take       = !rsp_valid_ff || rsp_tready;

   spicds_search u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (req_tvalid),
      .job    (job),
      .ready  (eng_ready),
      .done   (eng_done),
      .take   (take),
      .result (result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_done && take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, result.clock_rate, result.prescaler, result.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
